// ----- hw/rtl/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the checker file rpq_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define RPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// checked at every edge, reset included
`define RPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rpq_pkg.sv -----
// rpq_pkg: widths, register codes, default palette and stage-advance type
// for the palette quantizer. No dependencies.
package rpq_pkg;

    localparam int TABLE_DEPTH         = 16;
    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int IDX_W               = 4;
    localparam int CH_W                = 8;
    localparam int COLOR_W             = 3 * CH_W;
    localparam int SQ_W                = 2 * CH_W;
    localparam int DIST_W              = SQ_W + 2;
    localparam int GRP_SIZE            = 4;
    localparam int GRP_N               = TABLE_DEPTH / GRP_SIZE;
    localparam int ADDR_W              = 3;
    localparam int DATA_W              = 32;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic REG_ALPHA_THR  = 1'b0;
    localparam logic REG_TRANSP_IDX = 1'b1;

    localparam logic [CH_W-1:0]  ALPHA_THR_RST  = 8'd128;
    localparam logic [IDX_W-1:0] TRANSP_IDX_RST = 4'd15;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [COLOR_W-1:0] DEFAULT_PALETTE [TABLE_DEPTH] = '{
        24'h000000, 24'hFFFFFF, 24'h894036, 24'h7ABFC7,
        24'h8A46AE, 24'h68A941, 24'h3E31A2, 24'hD0DC71,
        24'h905F25, 24'h5C4700, 24'hBB776D, 24'h555555,
        24'h808080, 24'hACEA88, 24'h7C70DA, 24'hABABAB
    };

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_adv;

    typedef struct packed {
        logic transp;
        logic eoi;
    } t_side;

endpackage

// ----- hw/rtl/rpq_lane.sv -----
// rpq_lane: three-stage squared RGB distance for one palette entry.
// Depends on rpq_pkg.
module rpq_lane
    import rpq_pkg::*;
(
    input  logic               i_clk,
    input  t_adv               i_adv,
    input  logic [COLOR_W-1:0] i_entry,
    input  logic [CH_W-1:0]    i_red,
    input  logic [CH_W-1:0]    i_green,
    input  logic [CH_W-1:0]    i_blue,
    output logic [DIST_W-1:0]  o_dist
);

    logic [CH_W-1:0]   r_dr, r_dg, r_db;
    logic [CH_W-1:0]   n_dr, n_dg, n_db;
    logic [SQ_W-1:0]   r_sr, r_sg, r_sb;
    logic [DIST_W-1:0] r_dist;
    logic [CH_W-1:0]   w_er, w_eg, w_eb;

    assign w_er = i_entry[3*CH_W-1:2*CH_W];
    assign w_eg = i_entry[2*CH_W-1:CH_W];
    assign w_eb = i_entry[CH_W-1:0];

    always_comb begin
        n_dr = (w_er > i_red)   ? w_er - i_red   : i_red - w_er;
        n_dg = (w_eg > i_green) ? w_eg - i_green : i_green - w_eg;
        n_db = (w_eb > i_blue)  ? w_eb - i_blue  : i_blue - w_eb;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_dr <= n_dr;
            r_dg <= n_dg;
            r_db <= n_db;
        end
        if (i_adv.s2) begin
            r_sr <= SQ_W'(r_dr) * SQ_W'(r_dr);
            r_sg <= SQ_W'(r_dg) * SQ_W'(r_dg);
            r_sb <= SQ_W'(r_db) * SQ_W'(r_db);
        end
        if (i_adv.s3) begin
            r_dist <= DIST_W'(r_sr) + DIST_W'(r_sg) + DIST_W'(r_sb);
        end
    end

    assign o_dist = r_dist;

endmodule

// ----- hw/rtl/rgba_palette_quantizer.sv -----
// rgba_palette_quantizer: nearest-palette-entry search for RGBA pixels.
// Depends on rpq_pkg and rpq_lane.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   pixel   | i_valid/o_ready, i_kind..i_end_of_image | in
//   result  | o_valid/i_ready, o_color_index, o_end_of_image_out | out
//   config  | psel/penable/pwrite/paddr/pwdata/prdata/pready | APB
//
// One transaction per cycle while the output is not stalled; a pixel result
// passes through five register stages (abs diff, square, sum, group minimum,
// final minimum).
// Palette writes take effect at accept and give no result.
// Synchronous active-low reset restores the default palette and registers.
// A stall at the output backs up stage by stage; bubbles are squeezed out.
module rgba_palette_quantizer
    import rpq_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    input  logic [CH_W-1:0]   i_alpha,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic              i_end_of_image,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [IDX_W-1:0]  o_color_index,
    output logic              o_end_of_image_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [COLOR_W-1:0] r_palette [TABLE_DEPTH];
    logic [CH_W-1:0]    r_alpha_thr;
    logic [IDX_W-1:0]   r_transp_idx;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    t_adv w_adv;

    t_side r_sd1, r_sd2, r_sd3, r_sd4;

    logic [DIST_W-1:0] w_dist [TABLE_DEPTH];
    logic [DIST_W-1:0] r_gd   [GRP_N];
    logic [IDX_W-1:0]  r_gi   [GRP_N];
    logic [DIST_W-1:0] n_gd   [GRP_N];
    logic [IDX_W-1:0]  n_gi   [GRP_N];
    logic [DIST_W-1:0] n_bd;
    logic [IDX_W-1:0]  n_bi;
    logic [IDX_W-1:0]  r_color;
    logic              r_eoi;

    logic w_accept, w_cfg_wr;

    // ready chain
    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_adv.s1 = w_rdy1;
    assign w_adv.s2 = w_rdy2;
    assign w_adv.s3 = w_rdy3;

    assign w_accept = i_valid && o_ready;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[ADDR_W-1])
            REG_ALPHA_THR:  prdata = DATA_W'(r_alpha_thr);
            REG_TRANSP_IDX: prdata = DATA_W'(r_transp_idx);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_thr  <= ALPHA_THR_RST;
            r_transp_idx <= TRANSP_IDX_RST;
        end else if (w_cfg_wr) begin
            case (paddr[ADDR_W-1])
                REG_ALPHA_THR:  r_alpha_thr  <= pwdata[CH_W-1:0];
                REG_TRANSP_IDX: r_transp_idx <= pwdata[IDX_W-1:0];
                default:        r_alpha_thr  <= r_alpha_thr;
            endcase
        end
    end

    // palette table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette <= DEFAULT_PALETTE;
        end else if (w_accept && i_kind == KIND_WRITE) begin
            r_palette[i_entry_index] <= {i_red, i_green, i_blue};
        end
    end

    // distance lanes
    for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_slot
        if (c < PALETTE_ENTRIES) begin : g_lane
            rpq_lane u_lane (
                .i_clk   (i_clk),
                .i_adv   (w_adv),
                .i_entry (r_palette[c]),
                .i_red   (i_red),
                .i_green (i_green),
                .i_blue  (i_blue),
                .o_dist  (w_dist[c])
            );
        end else begin : g_pad
            assign w_dist[c] = DIST_MAX;
        end
    end

    // stage valids and side data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid && i_kind == KIND_PIXEL;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_sd1.transp <= i_alpha < r_alpha_thr;
            r_sd1.eoi    <= i_end_of_image;
        end
        if (w_rdy2) r_sd2 <= r_sd1;
        if (w_rdy3) r_sd3 <= r_sd2;
        if (w_rdy4) r_sd4 <= r_sd3;
    end

    // group minimum, lowest index on ties
    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            n_gd[g] = w_dist[g*GRP_SIZE];
            n_gi[g] = IDX_W'(g*GRP_SIZE);
            for (int k = 1; k < GRP_SIZE; k++) begin
                if (w_dist[g*GRP_SIZE+k] < n_gd[g]) begin
                    n_gd[g] = w_dist[g*GRP_SIZE+k];
                    n_gi[g] = IDX_W'(g*GRP_SIZE+k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_gd <= n_gd;
            r_gi <= n_gi;
        end
    end

    // final minimum
    always_comb begin
        n_bd = r_gd[0];
        n_bi = r_gi[0];
        for (int g = 1; g < GRP_N; g++) begin
            if (r_gd[g] < n_bd) begin
                n_bd = r_gd[g];
                n_bi = r_gi[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_color <= r_sd4.transp ? r_transp_idx : n_bi;
            r_eoi   <= r_sd4.eoi;
        end
    end

    assign o_valid            = r_v5;
    assign o_color_index      = r_color;
    assign o_end_of_image_out = r_eoi;

endmodule

// ----- hw/rtl/rpq_checker.sv -----
// rpq_checker: port-level assertions for rgba_palette_quantizer, bound to it.
// Depends on rpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpq_checker
    import rpq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [IDX_W-1:0]  o_color_index,
    input logic              o_end_of_image_out,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] prdata
);

    `RPQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_color_index) && $stable(o_end_of_image_out), "result changed while stalled")

    `RPQ_ASSERT(a_backpressure, i_clk, i_rst_n, !o_ready |-> o_valid && !i_ready, "input stalled without a stalled result")

    `RPQ_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")

    `RPQ_ASSERT_ALWAYS(a_thr_rst, i_clk, $past(!i_rst_n) && (paddr[ADDR_W-1] == REG_ALPHA_THR) |-> prdata == DATA_W'(ALPHA_THR_RST), "threshold not at reset value")

endmodule

bind rgba_palette_quantizer rpq_checker u_rpq_checker (.*);

// ----- dv/tb_rgba_palette_quantizer.sv -----
// tb_rgba_palette_quantizer: self-checking testbench for the palette quantizer.
// Depends on rpq_pkg and the rgba_palette_quantizer RTL. Directed and random
// pixel and palette-write traffic is checked against an in-bench predictor.
module tb_rgba_palette_quantizer;
    import rpq_pkg::*;

    localparam int NUM_ENTRIES  = PALETTE_ENTRIES_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 190;

    typedef struct packed {
        logic             kind;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic [IDX_W-1:0] entry;
        logic             eoi;
    } quant_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] color;
        logic             eoi;
    } quant_res_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_kind = KIND_PIXEL;
    logic [CH_W-1:0]   i_red = '0;
    logic [CH_W-1:0]   i_green = '0;
    logic [CH_W-1:0]   i_blue = '0;
    logic [CH_W-1:0]   i_alpha = '0;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic              i_end_of_image = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [IDX_W-1:0]  o_color_index;
    logic              o_end_of_image_out;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rgba_palette_quantizer #(.PALETTE_ENTRIES(NUM_ENTRIES)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .i_alpha            (i_alpha),
        .i_entry_index      (i_entry_index),
        .i_end_of_image     (i_end_of_image),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_color_index      (o_color_index),
        .o_end_of_image_out (o_end_of_image_out),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // predictor state
    logic [COLOR_W-1:0] palette_model [TABLE_DEPTH];
    logic [CH_W-1:0]    alpha_thr_model = ALPHA_THR_RST;
    logic [IDX_W-1:0]   transp_idx_model = TRANSP_IDX_RST;

    quant_req_t req_queue[$];
    quant_res_t expected_colors[$];
    quant_req_t cur_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_cnt = 0;
    int pixels_checked = 0;
    int transparent_cnt = 0;
    int writes_applied = 0;
    int cfg_settings = 0;
    int cycle_cnt = 0;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) palette_model[i] = DEFAULT_PALETTE[i];
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [IDX_W-1:0] nearest_index(input logic [CH_W-1:0] r,
                                                        input logic [CH_W-1:0] g,
                                                        input logic [CH_W-1:0] b);
        int best_dist;
        int d;
        int dr;
        int dg;
        int db;
        logic [IDX_W-1:0] best;
        logic [COLOR_W-1:0] e;
        best = '0;
        best_dist = 32'h7fffffff;
        for (int c = 0; c < NUM_ENTRIES; c++) begin
            e = palette_model[c[IDX_W-1:0]];
            dr = int'(e[2*CH_W +: CH_W]) - int'(r);
            dg = int'(e[CH_W +: CH_W]) - int'(g);
            db = int'(e[0 +: CH_W]) - int'(b);
            d = dr * dr + dg * dg + db * db;
            if (d < best_dist) begin
                best_dist = d;
                best = c[IDX_W-1:0];
            end
        end
        return best;
    endfunction

    // update palette copy or queue the expected result for an accepted transaction
    function automatic void quantize_accepted(input quant_req_t q);
        quant_res_t res;
        if (q.kind == KIND_WRITE) begin
            palette_model[q.entry] = {q.red, q.green, q.blue};
            writes_applied++;
        end else begin
            res.eoi = q.eoi;
            if (q.alpha < alpha_thr_model) begin
                res.color = transp_idx_model;
                transparent_cnt++;
            end else begin
                res.color = nearest_index(q.red, q.green, q.blue);
            end
            expected_colors.push_back(res);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) quantize_accepted(cur_req);
            if (!i_valid || o_ready) begin
                if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = req_queue.pop_front();
                    i_valid        <= 1'b1;
                    i_kind         <= cur_req.kind;
                    i_red          <= cur_req.red;
                    i_green        <= cur_req.green;
                    i_blue         <= cur_req.blue;
                    i_alpha        <= cur_req.alpha;
                    i_entry_index  <= cur_req.entry;
                    i_end_of_image <= cur_req.eoi;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        quant_res_t exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result color %0d eoi %0d",
                         $time, o_color_index, o_end_of_image_out);
                error_cnt++;
            end else begin
                exp_res = expected_colors.pop_front();
                pixels_checked++;
                if (o_color_index !== exp_res.color) begin
                    $display("%0t: color_index expected %0d actual %0d",
                             $time, exp_res.color, o_color_index);
                    error_cnt++;
                end
                if (o_end_of_image_out !== exp_res.eoi) begin
                    $display("%0t: end_of_image_out expected %0d actual %0d",
                             $time, exp_res.eoi, o_end_of_image_out);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_colors.size());
            $display("tb_rgba_palette_quantizer: errors");
            $finish;
        end
    end

    task automatic push_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic [CH_W-1:0] a,
                              input logic eoi);
        quant_req_t q;
        q.kind  = KIND_PIXEL;
        q.red   = r;
        q.green = g;
        q.blue  = b;
        q.alpha = a;
        q.entry = IDX_W'($urandom_range(TABLE_DEPTH - 1));
        q.eoi   = eoi;
        req_queue.push_back(q);
    endtask

    task automatic push_write(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] color,
                              input logic eoi);
        quant_req_t q;
        q.kind  = KIND_WRITE;
        q.red   = color[2*CH_W +: CH_W];
        q.green = color[CH_W +: CH_W];
        q.blue  = color[0 +: CH_W];
        q.alpha = CH_W'($urandom_range(255));
        q.entry = idx;
        q.eoi   = eoi;
        req_queue.push_back(q);
    endtask

    function automatic logic [CH_W-1:0] jitter(input logic [CH_W-1:0] v, input int span);
        int t;
        t = int'(v) + int'($urandom_range(2 * span)) - span;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return CH_W'(t);
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return CH_W'($urandom_range(255));
    endfunction

    task automatic push_random_item();
        int sel;
        logic [COLOR_W-1:0] base;
        logic [CH_W-1:0] a;
        sel = $urandom_range(99);
        if (sel < 12) begin
            push_write(IDX_W'($urandom_range(TABLE_DEPTH - 1)),
                       {rand_channel(), rand_channel(), rand_channel()},
                       1'($urandom_range(1)));
        end else begin
            if ($urandom_range(1)) a = CH_W'($urandom_range(255));
            else a = jitter(alpha_thr_model, 2);
            if (sel < 55) begin
                base = palette_model[IDX_W'($urandom_range(NUM_ENTRIES - 1))];
                push_pixel(jitter(base[2*CH_W +: CH_W], 6), jitter(base[CH_W +: CH_W], 6),
                           jitter(base[0 +: CH_W], 6), a, ($urandom_range(15) == 0));
            end else begin
                push_pixel(rand_channel(), rand_channel(), rand_channel(), a,
                           ($urandom_range(15) == 0));
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || i_valid || expected_colors.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_code, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_code, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [CH_W-1:0] thr, input logic [IDX_W-1:0] tidx,
                             input int s_pct, input int r_pct, input bit restore);
        wait_idle();
        cfg_write(REG_ALPHA_THR, DATA_W'(thr));
        cfg_write(REG_TRANSP_IDX, DATA_W'(tidx));
        alpha_thr_model = thr;
        transp_idx_model = tidx;
        cfg_settings++;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (restore) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                push_write(IDX_W'(i), DEFAULT_PALETTE[i], 1'b0);
            end
        end
        // alpha exactly at and, for a nonzero threshold, just below the threshold
        push_pixel(rand_channel(), rand_channel(), rand_channel(), thr, 1'b0);
        if (thr != 0) begin
            push_pixel(rand_channel(), rand_channel(), rand_channel(), CH_W'(thr - 1),
                       1'b1);
        end
        for (int i = 0; i < RAND_ITEMS; i++) push_random_item();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        send_idle_pct = 37;
        recv_idle_pct = 48;
        // directed part with reset register values
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'hAB, 8'hAB, 8'hAB, 8'd128, 1'b0);
        push_pixel(8'h80, 8'h80, 8'h80, 8'd127, 1'b0);
        push_pixel(8'h7C, 8'h70, 8'hDA, 8'h00, 1'b1);
        push_pixel(8'h7C, 8'h70, 8'hDA, 8'hFF, 1'b0);
        // duplicate entry: lower index wins, write marker dropped
        push_write(4'd9, 24'h8A46AE, 1'b1);
        push_pixel(8'h8A, 8'h46, 8'hAE, 8'd200, 1'b0);
        push_write(4'd0, 24'hFFFFFF, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_write(4'd0, 24'h000000, 1'b0);
        push_write(4'd15, 24'h123456, 1'b0);
        push_pixel(8'h12, 8'h34, 8'h56, 8'hFF, 1'b1);
        // equidistant distinct entries, then entry 14 duplicating entry 0
        push_write(4'd2, 24'h000010, 1'b0);
        push_write(4'd3, 24'h000012, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h11, 8'hFF, 1'b0);
        push_write(4'd14, 24'h000000, 1'b1);
        push_pixel(8'h01, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_write(4'd2, DEFAULT_PALETTE[2], 1'b0);
        push_write(4'd3, DEFAULT_PALETTE[3], 1'b0);
        push_write(4'd14, DEFAULT_PALETTE[14], 1'b0);
        push_write(4'd15, DEFAULT_PALETTE[15], 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);

        run_phase(8'd0, 4'd0, 37, 48, 1'b0);
        run_phase(8'd255, 4'd15, 37, 48, 1'b0);
        run_phase(CH_W'($urandom_range(255)), IDX_W'($urandom_range(15)), 48, 37, 1'b1);
        run_phase(8'd1, 4'd8, 48, 37, 1'b0);
        run_phase(CH_W'($urandom_range(255)), IDX_W'($urandom_range(15)), 0, 0, 1'b0);
        run_phase(ALPHA_THR_RST, TRANSP_IDX_RST, 0, 0, 1'b1);
        wait_idle();

        $display("covered %0d pixel results (%0d transparent), %0d palette writes,",
                 pixels_checked, transparent_cnt, writes_applied);
        $display("%0d register settings, three idle patterns", cfg_settings);
        if (error_cnt == 0) begin
            $display("tb_rgba_palette_quantizer: clean");
        end else begin
            $display("tb_rgba_palette_quantizer: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rpq_pkg.sv
hw/rtl/rpq_lane.sv
hw/rtl/rgba_palette_quantizer.sv
hw/rtl/rpq_checker.sv
dv/tb_rgba_palette_quantizer.sv
